FILE: hdl/robin_hood_hash_table_unit_assert.svh
// Assertion macros for the Robin Hood hash table unit.
`ifndef ROBIN_HOOD_HASH_TABLE_UNIT_ASSERT_SVH
`define ROBIN_HOOD_HASH_TABLE_UNIT_ASSERT_SVH
`ifndef SYNTH
`define RH_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define RH_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define RH_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define RH_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: hdl/rhht_pkg.sv
// Package with constants, types and helpers of the Robin Hood hash table unit.
package rhht_pkg;
    localparam int SLOTS = 1024;
    localparam int IDX_BITS = $clog2(SLOTS);
    localparam int KEY_W = 32;
    localparam int VAL_W = 32;
    localparam int TAG_W = 32;
    localparam int CNT_W = 11;
    localparam int STEP_W = $clog2(4 * SLOTS) + 1;
    localparam int MIN_ENTRIES = 8;

    localparam logic [1:0] OP_LOOKUP = 2'd0;
    localparam logic [1:0] OP_PUT = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;

    localparam logic [TAG_W-1:0] DEAD_BIT = 32'h8000_0000;

    // Largest entry count before the new one that a put still accepts.
    function automatic logic [CNT_W-1:0] max_live();
        int m;
        int need;
        int p;
        int best;
        best = 0;
        for (int n = 0; n < SLOTS; n++) begin
            m = (n + 1 < MIN_ENTRIES) ? MIN_ENTRIES : n + 1;
            need = m + m / 10;
            p = 1;
            while (p < need) p = p * 2;
            if (p <= SLOTS) best = n;
        end
        return CNT_W'(best);
    endfunction

    localparam logic [CNT_W-1:0] LIVE_LIMIT = max_live();

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_WAIT,
        ST_EVAL,
        ST_WRITE,
        ST_FALLBACK,
        ST_FB_EVAL,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load;
        logic eval;
        logic fb_eval;
        logic fin;
    } cmd_t;

    typedef struct packed {
        logic match;
        logic stop;
        logic swap;
        logic fb_free;
        logic is_put;
        logic refused;
        logic bad_op;
        logic step_end;
        logic fb_end;
    } stat_t;
endpackage

FILE: hdl/rhht_ram.sv
// Generic single-port RAM with registered read.
module rhht_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

FILE: hdl/rhht_ctrl.sv
// Control state machine of the Robin Hood hash table unit.
module rhht_ctrl
    import rhht_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    output logic  out_valid,
    input  logic  out_ready,
    input  logic  clr_done,
    input  stat_t st,
    output cmd_t  cmd
);
    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        in_ready = 1'b0;
        out_valid = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = clr_done;
                if (in_valid && clr_done)
                begin
                    cmd.load = 1'b1;
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                if (st.bad_op || (st.is_put && st.refused))
                begin
                    cmd.fin = 1'b1;
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT: state_next = ST_EVAL;
            ST_EVAL:
            begin
                cmd.eval = 1'b1;
                if (st.match || st.stop)
                begin
                    cmd.fin = 1'b1;
                    state_next = ST_DONE;
                end
                else if (st.step_end)
                begin
                    state_next = st.is_put ? ST_FALLBACK : ST_DONE;
                    cmd.fin = !st.is_put;
                end
                else
                begin
                    state_next = ST_READ;
                end
            end
            ST_FALLBACK:
            begin
                state_next = ST_FB_EVAL;
            end
            ST_FB_EVAL:
            begin
                state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                cmd.fb_eval = 1'b1;
                if (st.fb_free || st.fb_end)
                begin
                    cmd.fin = 1'b1;
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_FALLBACK;
                end
            end
            ST_DONE:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end
endmodule

FILE: hdl/rhht_dp.sv
// Datapath of the Robin Hood hash table unit: slot memories, probe registers, counters.
module rhht_dp
    import rhht_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  cmd_t             cmd,
    output stat_t            st,
    output logic             clr_done,
    input  logic [1:0]       op,
    input  logic [KEY_W-1:0] key,
    input  logic [31:0]      raw_hash,
    input  logic [VAL_W-1:0] value_in,
    output logic             found,
    output logic [VAL_W-1:0] value_out,
    output logic             status,
    output logic             added_new,
    output logic [CNT_W-1:0] entry_count
);
    logic [1:0]          op_reg;
    logic [TAG_W-1:0]    tag_reg;
    logic [KEY_W-1:0]    key_reg;
    logic [VAL_W-1:0]    val_reg;
    logic [IDX_BITS-1:0] pos_reg;
    logic [IDX_BITS:0]   dist_reg;
    logic [STEP_W-1:0]   step_reg;
    logic [CNT_W-1:0]    live_reg;
    logic                found_reg, status_reg, added_reg;
    logic [VAL_W-1:0]    vout_reg;
    logic [IDX_BITS:0]   clr_reg;

    logic                we;
    logic [IDX_BITS-1:0] addr;
    logic [TAG_W-1:0]    tag_w, tag_r;
    logic [KEY_W-1:0]    key_w, key_r;
    logic [VAL_W-1:0]    val_w, val_r;
    logic [TAG_W-1:0]    tag_in;
    logic [IDX_BITS-1:0] cd;
    logic                clearing;

    assign clearing = !clr_reg[IDX_BITS];
    assign clr_done = !clearing;
    assign tag_in = ({1'b0, raw_hash[30:0]} == '0) ? TAG_W'(1) : {1'b0, raw_hash[30:0]};
    assign cd = pos_reg - tag_r[IDX_BITS-1:0];

    rhht_ram #(.WIDTH(TAG_W), .DEPTH(SLOTS)) u_tag
        (.clk(clk), .we(we), .addr(addr), .wdata(tag_w), .rdata(tag_r));
    rhht_ram #(.WIDTH(KEY_W), .DEPTH(SLOTS)) u_key
        (.clk(clk), .we(we && !clearing), .addr(addr), .wdata(key_w), .rdata(key_r));
    rhht_ram #(.WIDTH(VAL_W), .DEPTH(SLOTS)) u_val
        (.clk(clk), .we(we && !clearing), .addr(addr), .wdata(val_w), .rdata(val_r));

    always_comb
    begin
        st.is_put = (op_reg == OP_PUT);
        st.bad_op = !(op_reg == OP_LOOKUP || op_reg == OP_PUT || op_reg == OP_REMOVE);
        st.refused = (live_reg > LIVE_LIMIT);
        st.match = (tag_r == tag_reg) && (key_r == key_reg);
        st.stop = (tag_r == '0) ||
                  (({1'b0, cd} < dist_reg) && (!st.is_put || tag_r[TAG_W-1]));
        st.swap = (tag_r != '0) && ({1'b0, cd} < dist_reg);
        st.fb_free = (tag_r == '0) || tag_r[TAG_W-1];
        st.step_end = st.is_put ? (step_reg == STEP_W'(4 * SLOTS - 1))
                                : (step_reg == STEP_W'(SLOTS));
        st.fb_end = (step_reg == STEP_W'(SLOTS - 1));
    end

    always_comb
    begin
        we = 1'b0;
        addr = pos_reg;
        tag_w = tag_reg;
        key_w = key_reg;
        val_w = val_reg;
        if (clearing)
        begin
            we = 1'b1;
            addr = clr_reg[IDX_BITS-1:0];
            tag_w = '0;
        end
        else if (cmd.eval && st.is_put && (st.match || tag_r == '0 || st.swap))
        begin
            we = 1'b1;
        end
        else if (cmd.eval && op_reg == OP_REMOVE && st.match)
        begin
            we = 1'b1;
            tag_w = tag_r | DEAD_BIT;
            key_w = key_r;
            val_w = '0;
        end
        else if (cmd.fb_eval && st.fb_free)
        begin
            we = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg <= '0;
            live_reg <= '0;
        end
        else
        begin
            if (clearing)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (cmd.eval && st.is_put && !st.match && tag_r == '0)
            begin
                live_reg <= live_reg + 1'b1;
            end
            else if (cmd.eval && st.is_put && !st.match && st.swap && tag_r[TAG_W-1])
            begin
                live_reg <= live_reg + 1'b1;
            end
            else if (cmd.eval && op_reg == OP_REMOVE && st.match && live_reg != '0)
            begin
                live_reg <= live_reg - 1'b1;
            end
            else if (cmd.fb_eval && st.fb_free)
            begin
                live_reg <= live_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg <= op;
            tag_reg <= tag_in;
            key_reg <= key;
            val_reg <= value_in;
            pos_reg <= tag_in[IDX_BITS-1:0];
            dist_reg <= '0;
            step_reg <= '0;
            found_reg <= 1'b0;
            status_reg <= 1'b0;
            added_reg <= 1'b0;
            vout_reg <= '0;
        end
        else if (cmd.fin && !cmd.eval && !cmd.fb_eval)
        begin
            status_reg <= st.is_put && st.refused;
        end
        else if (cmd.eval)
        begin
            if (st.match)
            begin
                found_reg <= !st.is_put;
                vout_reg <= (op_reg == OP_LOOKUP) ? val_r : '0;
            end
            else if (st.is_put && (tag_r == '0 || (st.swap && tag_r[TAG_W-1])))
            begin
                added_reg <= 1'b1;
            end
            else
            begin
                if (st.is_put && st.swap)
                begin
                    tag_reg <= tag_r;
                    key_reg <= key_r;
                    val_reg <= val_r;
                    dist_reg <= {1'b0, cd} + 1'b1;
                end
                else
                begin
                    dist_reg <= dist_reg + 1'b1;
                end
                pos_reg <= pos_reg + 1'b1;
                step_reg <= st.step_end ? '0 : step_reg + 1'b1;
            end
        end
        else if (cmd.fb_eval)
        begin
            if (st.fb_free)
            begin
                added_reg <= 1'b1;
            end
            else
            begin
                pos_reg <= pos_reg + 1'b1;
                step_reg <= step_reg + 1'b1;
            end
        end
    end

    assign found = found_reg;
    assign value_out = vout_reg;
    assign status = status_reg;
    assign added_new = added_reg;
    assign entry_count = live_reg;
endmodule

FILE: hdl/robin_hood_hash_table_unit.sv
// Robin Hood hash table unit with 1024 slots. After reset the tag memory is
// cleared slot by slot, during which no beat is accepted. Each probed slot
// then passes through the READ, WAIT and EVAL states, as the slot memories
// are single-port with registered read; a put refused by the load limit and
// an unused op code finish from the READ state without a probe. A put that keeps
// displacing entries may walk up to 4096 slots before a final search of up to
// 1024 more. One operation is in flight at a time, and its result is held
// until the output beat is taken.
module robin_hood_hash_table_unit
    import rhht_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [1:0]       op,
    input  logic [KEY_W-1:0] key,
    input  logic [31:0]      raw_hash,
    input  logic [VAL_W-1:0] value_in,
    output logic             out_valid,
    input  logic             out_ready,
    output logic             found,
    output logic [VAL_W-1:0] value_out,
    output logic             status,
    output logic             added_new,
    output logic [CNT_W-1:0] entry_count
);
    `include "robin_hood_hash_table_unit_assert.svh"

    cmd_t  cmd;
    stat_t st;
    logic  clr_done;

    rhht_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .out_valid(out_valid), .out_ready(out_ready), .clr_done(clr_done),
        .st(st), .cmd(cmd)
    );

    rhht_dp u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .st(st), .clr_done(clr_done),
        .op(op), .key(key), .raw_hash(raw_hash), .value_in(value_in),
        .found(found), .value_out(value_out), .status(status),
        .added_new(added_new), .entry_count(entry_count)
    );

    `RH_ASSERT_IMPL(a_no_accept_in_clear, clk, rst_n, !clr_done, !in_ready)
    `RH_ASSERT_IMPL(a_not_both, clk, rst_n, in_ready, !out_valid)
    `RH_ASSERT_NEXT(a_count_bound, clk, rst_n, 1'b1, entry_count <= CNT_W'(SLOTS))
endmodule
